[src/bep_pkg.sv]
`timescale 1ns / 1ps

package bep_pkg;

  localparam int MAX_WIDTH_DEF       = 1024;
  localparam int PALETTE_ENTRIES_DEF = 256;
  localparam int SMALL_N             = 4;

  localparam logic OP_PALETTE = 1'b0;
  localparam logic OP_PIXEL   = 1'b1;

  localparam logic [2:0] DEPTH_1  = 3'd0;
  localparam logic [2:0] DEPTH_2  = 3'd1;
  localparam logic [2:0] DEPTH_4  = 3'd2;
  localparam logic [2:0] DEPTH_8  = 3'd3;
  localparam logic [2:0] DEPTH_16 = 3'd4;
  localparam logic [2:0] DEPTH_24 = 3'd5;
  localparam logic [2:0] DEPTH_32 = 3'd6;

  localparam logic [1:0] REG_DEPTH  = 2'd0;
  localparam logic [1:0] REG_RGB565 = 2'd1;
  localparam logic [1:0] REG_COLOR  = 2'd2;
  localparam logic [1:0] REG_WIDTH  = 2'd3;

  localparam logic [7:0] WHITE_LEVEL = 8'h80;
  localparam logic [9:0] WHITE_SUM   = 10'd384;
  localparam logic [7:0] COLOR_LEVEL = 8'hF0;

  typedef struct packed {
    logic white;
    logic colour;
  } pal_ent_t;

  function automatic pal_ent_t classify(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                        logic col_on);
    pal_ent_t e;
    logic [9:0] sum;
    sum = {2'b00, r} + {2'b00, g} + {2'b00, b};
    if (col_on) begin
      e.white = (r > WHITE_LEVEL) && (g > WHITE_LEVEL) && (b > WHITE_LEVEL);
    end else begin
      e.white = sum > WHITE_SUM;
    end
    e.colour = (r > COLOR_LEVEL) || ((g > COLOR_LEVEL) && (b > COLOR_LEVEL));
    return e;
  endfunction

endpackage

[src/bep_in_if.sv]
`timescale 1ns / 1ps

interface bep_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] palette_index;
  logic [7:0] red_value;
  logic [7:0] green_value;
  logic [7:0] blue_value;
  logic [7:0] data_byte;

  modport source (
    output valid, opcode, palette_index, red_value, green_value, blue_value, data_byte,
    input  ready
  );

  modport sink (
    input  valid, opcode, palette_index, red_value, green_value, blue_value, data_byte,
    output ready
  );
endinterface

[src/bep_out_if.sv]
`timescale 1ns / 1ps

interface bep_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] mono_byte;
  logic [7:0] color_byte;
  logic [6:0] byte_position;
  logic       row_last;

  modport source (
    output valid, mono_byte, color_byte, byte_position, row_last,
    input  ready
  );

  modport sink (
    input  valid, mono_byte, color_byte, byte_position, row_last,
    output ready
  );
endinterface

[src/bep_palette.sv]
`timescale 1ns / 1ps

module bep_palette #(
  parameter int ENTRIES = bep_pkg::PALETTE_ENTRIES_DEF
) (
  input  logic                                         clk,
  input  logic                                         wr_en,
  input  logic [7:0]                                   wr_index,
  input  bep_pkg::pal_ent_t                            wr_ent,
  input  logic                                         rd_en,
  input  logic [7:0]                                   rd_addr0,
  input  logic [7:0]                                   rd_addr1,
  output bep_pkg::pal_ent_t                            rd_ent0,
  output bep_pkg::pal_ent_t                            rd_ent1,
  output bep_pkg::pal_ent_t [bep_pkg::SMALL_N-1:0]     small_ent
);

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  bep_pkg::pal_ent_t mem [ENTRIES];

  logic wr_ok;
  logic rd_ok0;
  logic rd_ok1;

  assign wr_ok  = {1'b0, wr_index} < 9'(ENTRIES);
  assign rd_ok0 = {1'b0, rd_addr0} < 9'(ENTRIES);
  assign rd_ok1 = {1'b0, rd_addr1} < 9'(ENTRIES);

  always_ff @(posedge clk) begin
    if (wr_en && wr_ok) begin
      mem[wr_index[AW-1:0]] <= wr_ent;
    end
    if (rd_en) begin
      rd_ent0 <= rd_ok0 ? mem[rd_addr0[AW-1:0]] : '0;
      rd_ent1 <= rd_ok1 ? mem[rd_addr1[AW-1:0]] : '0;
    end
  end

  // low entries kept in flops for the 1- and 2-bit depths
  always_ff @(posedge clk) begin
    if (wr_en && wr_ok && (wr_index < 8'(bep_pkg::SMALL_N))) begin
      small_ent[wr_index[1:0]] <= wr_ent;
    end
  end

endmodule

[src/bmp_row_to_epaper_bitplanes.sv]
`timescale 1ns / 1ps

// BMP row bytes to packed e-paper bitplanes (black plane and colour plane).
// feed: one item per cycle; opcode selects a palette entry write or a raw row
// byte. Palette writes are classified and stored as they are accepted and make
// no result. Row bytes are decoded at the configured depth; 1/2/4/8-bit pixels
// go through the palette, 16/24/32-bit pixels are decoded directly.
// result: one item per 8 pixels and at the end of each row, MSB first, with
// the byte index in the row and a last flag. Row padding gives no result.
// Throughput is one item per cycle unless result stalls. A row byte that
// completes an output byte is held in the input stage with the registered
// palette read; the decode/pack logic then loads the output register.
// When result stalls, the output register holds its item; the pack stage keeps
// taking bytes that produce no output and stalls only on the next output byte,
// and feed.ready drops then.
// Reset (rst, synchronous) clears the row state and loads the register
// defaults (32 bpp, 555, mono, 128 pixels). Palette contents are not cleared.
// Registers are written over the APB port with a setup and an access phase.
module bmp_row_to_epaper_bitplanes #(
  parameter int MAX_WIDTH       = bep_pkg::MAX_WIDTH_DEF,
  parameter int PALETTE_ENTRIES = bep_pkg::PALETTE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  bep_in_if.sink      feed,
  bep_out_if.source   result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CW   = $clog2(MAX_WIDTH + 1);
  localparam int CMPW = (CW > 11) ? CW : 11;
  localparam int RB   = $clog2(4 * MAX_WIDTH + 1);
  localparam int RSW  = RB + 1;

  // configuration
  logic [2:0]  depth_code;
  logic        rgb565_mode;
  logic        color_enable;
  logic [10:0] image_width;

  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_code   <= bep_pkg::DEPTH_32;
      rgb565_mode  <= 1'b0;
      color_enable <= 1'b0;
      image_width  <= 11'd128;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        bep_pkg::REG_DEPTH:  depth_code   <= pwdata[2:0];
        bep_pkg::REG_RGB565: rgb565_mode  <= pwdata[0];
        bep_pkg::REG_COLOR:  color_enable <= pwdata[0];
        bep_pkg::REG_WIDTH:  image_width  <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      bep_pkg::REG_DEPTH:  prdata = {29'd0, depth_code};
      bep_pkg::REG_RGB565: prdata = {31'd0, rgb565_mode};
      bep_pkg::REG_COLOR:  prdata = {31'd0, color_enable};
      bep_pkg::REG_WIDTH:  prdata = {21'd0, image_width};
      default:             prdata = '0;
    endcase
  end

  // effective settings
  logic [2:0]     code;
  logic           col_on;
  logic [CW-1:0]  w_eff;
  logic [CMPW-1:0] iw_x;
  logic [RSW-1:0] wx;
  logic [RSW-1:0] row_bytes;
  logic [RSW-1:0] row_bytes_p3;
  logic [RSW-1:0] row_size;

  always_comb begin
    code   = (depth_code > bep_pkg::DEPTH_32) ? bep_pkg::DEPTH_32 : depth_code;
    col_on = color_enable && (code != bep_pkg::DEPTH_1);
    iw_x   = CMPW'(image_width);
    if (image_width == '0) begin
      w_eff = CW'(1);
    end else if (iw_x > CMPW'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(iw_x);
    end
    wx = RSW'(w_eff);
    case (code)
      bep_pkg::DEPTH_1:  row_bytes = (wx + RSW'(7)) >> 3;
      bep_pkg::DEPTH_2:  row_bytes = (wx + RSW'(3)) >> 2;
      bep_pkg::DEPTH_4:  row_bytes = (wx + RSW'(1)) >> 1;
      bep_pkg::DEPTH_8:  row_bytes = wx;
      bep_pkg::DEPTH_16: row_bytes = wx << 1;
      bep_pkg::DEPTH_24: row_bytes = wx + (wx << 1);
      default:           row_bytes = wx << 2;
    endcase
    row_bytes_p3 = row_bytes + RSW'(3);
    row_size     = {row_bytes_p3[RSW-1:2], 2'b00};
  end

  // input stage and palette
  logic feed_acc;
  logic s1_valid;
  logic s1_go;
  logic [7:0] s1_byte;

  bep_pkg::pal_ent_t                        rd_ent0;
  bep_pkg::pal_ent_t                        rd_ent1;
  bep_pkg::pal_ent_t [bep_pkg::SMALL_N-1:0] small_ent;

  assign feed_acc   = feed.valid && feed.ready;
  assign feed.ready = !s1_valid || s1_go;

  bep_palette #(
    .ENTRIES (PALETTE_ENTRIES)
  ) u_palette (
    .clk       (clk),
    .wr_en     (feed_acc && (feed.opcode == bep_pkg::OP_PALETTE)),
    .wr_index  (feed.palette_index),
    .wr_ent    (bep_pkg::classify(feed.red_value, feed.green_value, feed.blue_value,
                                  col_on)),
    .rd_en     (feed_acc && (feed.opcode == bep_pkg::OP_PIXEL)),
    .rd_addr0  ((code == bep_pkg::DEPTH_8) ? feed.data_byte : {4'd0, feed.data_byte[7:4]}),
    .rd_addr1  ({4'd0, feed.data_byte[3:0]}),
    .rd_ent0   (rd_ent0),
    .rd_ent1   (rd_ent1),
    .small_ent (small_ent)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (feed_acc && (feed.opcode == bep_pkg::OP_PIXEL)) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (feed_acc) begin
      s1_byte <= feed.data_byte;
    end
  end

  // row state
  logic [1:0]    phase;
  logic [23:0]   partial;
  logic [CW-1:0] col;
  logic [RB-1:0] rbc;
  logic [7:0]    mono_acc;
  logic [7:0]    color_acc;

  logic [1:0]    phase_next;
  logic [23:0]   partial_next;
  logic [CW-1:0] col_next;
  logic [RB-1:0] rbc_next;
  logic [7:0]    mono_acc_next;
  logic [7:0]    color_acc_next;

  // decode / pack
  logic [2:0]   ph_sum;
  logic [2:0]   need;
  logic [23:0]  part_upd;
  logic         complete;
  logic [7:0]   pr;
  logic [7:0]   pg;
  logic [7:0]   pb;
  bep_pkg::pal_ent_t direct_ent;
  bep_pkg::pal_ent_t lane_ent;
  logic         col_ok;
  logic         pal_mode;
  logic [1:0]   sidx;
  logic         active;
  logic         blocked;
  logic         proc_k;
  logic         at_end;
  logic [CW:0]  col_k;
  logic [3:0]   cnt;
  logic [7:0]   bitmask;
  logic [7:0]   mono_clr;
  logic [7:0]   color_clr;
  logic         emit;
  logic         emit_last;
  logic [7:0]   mono_new;
  logic [7:0]   color_new;
  logic [CW+6:0] col_ext;
  logic [RSW-1:0] rbc_inc;
  logic         restart;

  always_comb begin
    ph_sum   = {1'b0, phase} + 3'd1;
    need     = (code == bep_pkg::DEPTH_16) ? 3'd2 :
               ((code == bep_pkg::DEPTH_24) ? 3'd3 : 3'd4);
    part_upd = partial;
    case (phase)
      2'd0:    part_upd[7:0]   = s1_byte;
      2'd1:    part_upd[15:8]  = s1_byte;
      2'd2:    part_upd[23:16] = s1_byte;
      default: ;
    endcase
    complete = ph_sum >= need;

    if (code == bep_pkg::DEPTH_16) begin
      pb = {part_upd[4:0], 3'b000};
      if (rgb565_mode) begin
        pg = {part_upd[10:8], part_upd[7:5], 2'b00};
        pr = {part_upd[15:11], 3'b000};
      end else begin
        pg = {part_upd[9:8], part_upd[7:5], 3'b000};
        pr = {part_upd[14:10], 3'b000};
      end
    end else begin
      pb = part_upd[7:0];
      pg = part_upd[15:8];
      pr = part_upd[23:16];
    end
    direct_ent = bep_pkg::classify(pr, pg, pb, col_on);

    col_ok   = col < w_eff;
    pal_mode = code <= bep_pkg::DEPTH_8;

    blocked   = 1'b0;
    cnt       = '0;
    mono_clr  = '0;
    color_clr = '0;
    emit      = 1'b0;
    emit_last = 1'b0;
    for (int k = 0; k < 8; k++) begin
      lane_ent = '0;
      active   = 1'b0;
      sidx     = '0;
      if (pal_mode) begin
        case (code)
          bep_pkg::DEPTH_1: begin
            active = 1'b1;
            sidx   = {1'b0, s1_byte[7-k]};
          end
          bep_pkg::DEPTH_2: begin
            active = k < 4;
            sidx   = 2'(s1_byte >> (2 * (3 - (k & 3))));
          end
          bep_pkg::DEPTH_4: begin
            active   = k < 2;
            lane_ent = (k == 0) ? rd_ent0 : rd_ent1;
          end
          default: begin
            active   = k == 0;
            lane_ent = rd_ent0;
          end
        endcase
        if ((code == bep_pkg::DEPTH_1) || (code == bep_pkg::DEPTH_2)) begin
          lane_ent = (9'(sidx) < 9'(PALETTE_ENTRIES)) ? small_ent[sidx] : '0;
        end
      end else begin
        active   = (k == 0) && complete;
        lane_ent = direct_ent;
      end
      proc_k  = active && col_ok && !blocked;
      col_k   = (CW+1)'(col) + (CW+1)'(k);
      at_end  = (col_k + (CW+1)'(1)) >= (CW+1)'(w_eff);
      bitmask = 8'h80 >> (col[2:0] + 3'(k));
      if (proc_k) begin
        cnt = cnt + 4'd1;
        if (!lane_ent.white) begin
          if (lane_ent.colour && col_on) begin
            color_clr = color_clr | bitmask;
          end else begin
            mono_clr = mono_clr | bitmask;
          end
        end
        if ((col_k[2:0] == 3'd7) || at_end) begin
          emit      = 1'b1;
          emit_last = at_end;
          blocked   = 1'b1;
        end
      end
    end

    mono_new  = mono_acc & ~mono_clr;
    color_new = color_acc & ~color_clr;
    col_ext   = {7'd0, col};

    col_next       = col + CW'(cnt);
    mono_acc_next  = emit ? 8'hFF : mono_new;
    color_acc_next = emit ? 8'hFF : color_new;
    phase_next     = phase;
    partial_next   = partial;
    if (!pal_mode && col_ok) begin
      phase_next   = complete ? 2'd0 : ph_sum[1:0];
      partial_next = part_upd;
    end

    rbc_inc  = RSW'(rbc) + RSW'(1);
    restart  = rbc_inc >= row_size;
    rbc_next = rbc_inc[RB-1:0];
    if (restart) begin
      phase_next     = '0;
      partial_next   = '0;
      col_next       = '0;
      rbc_next       = '0;
      mono_acc_next  = 8'hFF;
      color_acc_next = 8'hFF;
    end
  end

  logic       out_valid;
  logic [7:0] out_mono;
  logic [7:0] out_color;
  logic [6:0] out_pos;
  logic       out_last;

  assign s1_go = s1_valid && (!emit || !out_valid || result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= '0;
      partial   <= '0;
      col       <= '0;
      rbc       <= '0;
      mono_acc  <= 8'hFF;
      color_acc <= 8'hFF;
    end else if (s1_go) begin
      phase     <= phase_next;
      partial   <= partial_next;
      col       <= col_next;
      rbc       <= rbc_next;
      mono_acc  <= mono_acc_next;
      color_acc <= color_acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && emit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && emit) begin
      out_mono  <= mono_new;
      out_color <= color_new;
      out_pos   <= col_ext[9:3];
      out_last  <= emit_last;
    end
  end

  assign result.valid         = out_valid;
  assign result.mono_byte     = out_mono;
  assign result.color_byte    = out_color;
  assign result.byte_position = out_pos;
  assign result.row_last      = out_last;

endmodule

[tb/sv/bmp_row_to_epaper_bitplanes_test.sv]
`timescale 1ns / 1ps

typedef struct packed {
  bit       opcode;
  bit [7:0] idx;
  bit [7:0] red;
  bit [7:0] green;
  bit [7:0] blue;
  bit [7:0] data;
} feed_item_t;

typedef struct packed {
  logic [7:0] mono;
  logic [7:0] color;
  logic [6:0] pos;
  logic       last;
} plane_byte_t;

class plane_scoreboard;
  bit          pal_white[256];
  bit          pal_color[256];
  bit [1:0]    phase;
  bit [23:0]   partial;
  int unsigned column;
  int unsigned row_bytes;
  bit [7:0]    mono_acc;
  bit [7:0]    color_acc;
  bit [2:0]    depth;
  bit          rgb565;
  bit          color_en;
  bit [10:0]   width;
  plane_byte_t pending[$];
  int          failures;

  function new();
    restart_row();
    depth    = bep_pkg::DEPTH_32;
    rgb565   = 1'b0;
    color_en = 1'b0;
    width    = 11'd128;
    failures = 0;
  endfunction

  function void restart_row();
    phase     = 2'd0;
    partial   = 24'd0;
    column    = 0;
    row_bytes = 0;
    mono_acc  = 8'hFF;
    color_acc = 8'hFF;
  endfunction

  function void write_reg(logic [1:0] idx, logic [31:0] value);
    case (idx)
      bep_pkg::REG_DEPTH:  depth    = value[2:0];
      bep_pkg::REG_RGB565: rgb565   = value[0];
      bep_pkg::REG_COLOR:  color_en = value[0];
      bep_pkg::REG_WIDTH:  width    = value[10:0];
      default: ;
    endcase
  endfunction

  function bit [2:0] eff_depth();
    return (depth > bep_pkg::DEPTH_32) ? bep_pkg::DEPTH_32 : depth;
  endfunction

  function int unsigned cols();
    if (width == 0) return 1;
    if (width > bep_pkg::MAX_WIDTH_DEF) return bep_pkg::MAX_WIDTH_DEF;
    return width;
  endfunction

  function bit colour_mode();
    return color_en && (eff_depth() != bep_pkg::DEPTH_1);
  endfunction

  function int unsigned pixel_bits();
    case (eff_depth())
      bep_pkg::DEPTH_1:  return 1;
      bep_pkg::DEPTH_2:  return 2;
      bep_pkg::DEPTH_4:  return 4;
      bep_pkg::DEPTH_8:  return 8;
      bep_pkg::DEPTH_16: return 16;
      bep_pkg::DEPTH_24: return 24;
      default:           return 32;
    endcase
  endfunction

  function int unsigned row_len();
    int unsigned bytes;
    bytes = (cols() * pixel_bits() + 7) / 8;
    return (bytes + 3) & ~32'd3;
  endfunction

  function bit white_test(bit [7:0] r, bit [7:0] g, bit [7:0] b);
    if (colour_mode())
      return (r > bep_pkg::WHITE_LEVEL) && (g > bep_pkg::WHITE_LEVEL) &&
             (b > bep_pkg::WHITE_LEVEL);
    return (int'(r) + int'(g) + int'(b)) > int'(bep_pkg::WHITE_SUM);
  endfunction

  function bit colour_test(bit [7:0] r, bit [7:0] g, bit [7:0] b);
    return (r > bep_pkg::COLOR_LEVEL) ||
           ((g > bep_pkg::COLOR_LEVEL) && (b > bep_pkg::COLOR_LEVEL));
  endfunction

  function bit pack_pixel(bit white, bit coloured, output plane_byte_t res);
    bit [7:0] mask;
    bit       done;
    mask = 8'h80 >> column[2:0];
    done = 1'b0;
    if (!white) begin
      if (coloured && colour_mode()) color_acc &= ~mask;
      else mono_acc &= ~mask;
    end
    if (column[2:0] == 3'd7 || column + 1 >= cols()) begin
      res.mono  = mono_acc;
      res.color = color_acc;
      res.pos   = 7'((column >> 3) & 32'h7F);
      res.last  = (column + 1 >= cols());
      mono_acc  = 8'hFF;
      color_acc = 8'hFF;
      done      = 1'b1;
    end
    column++;
    return done;
  endfunction

  function void note_item(feed_item_t it);
    plane_byte_t res;
    bit          got;
    int unsigned bits, per, idx, need, ph;
    bit [7:0]    r, g, b, b0, b1, b2;
    got = 1'b0;
    if (it.opcode == bep_pkg::OP_PALETTE) begin
      pal_white[it.idx] = white_test(it.red, it.green, it.blue);
      pal_color[it.idx] = colour_test(it.red, it.green, it.blue);
      return;
    end
    if (column < cols()) begin
      if (eff_depth() <= bep_pkg::DEPTH_8) begin
        bits = pixel_bits();
        per  = 8 / bits;
        for (int k = 0; k < per; k++) begin
          if (got || column >= cols()) break;
          idx = (int'(it.data) >> (8 - bits * (k + 1))) & ((1 << bits) - 1);
          got = pack_pixel(pal_white[idx], pal_color[idx], res);
        end
      end else begin
        need = (eff_depth() == bep_pkg::DEPTH_16) ? 2 :
               (eff_depth() == bep_pkg::DEPTH_24) ? 3 : 4;
        ph = phase;
        if (ph < 3) partial[8*ph +: 8] = it.data;
        ph++;
        if (ph >= need) begin
          b0 = partial[7:0];
          b1 = partial[15:8];
          b2 = partial[23:16];
          if (eff_depth() == bep_pkg::DEPTH_16) begin
            b = {b0[4:0], 3'b000};
            if (rgb565) begin
              g = {b1[2:0], b0[7:5], 2'b00};
              r = {b1[7:3], 3'b000};
            end else begin
              g = {b1[1:0], b0[7:5], 3'b000};
              r = {b1[6:2], 3'b000};
            end
          end else begin
            b = b0;
            g = b1;
            r = b2;
          end
          got = pack_pixel(white_test(r, g, b), colour_test(r, g, b), res);
          ph = 0;
        end
        phase = ph[1:0];
      end
    end
    row_bytes++;
    if (row_bytes >= row_len()) restart_row();
    if (got) pending.push_back(res);
  endfunction

  function void flag(string what, plane_byte_t exp_b, plane_byte_t act_b);
    failures++;
    if (failures <= 10)
      $display({"%0t %s: expected mono %02h color %02h pos %0d last %0d,",
                " got mono %02h color %02h pos %0d last %0d"},
               $time, what, exp_b.mono, exp_b.color, exp_b.pos, exp_b.last,
               act_b.mono, act_b.color, act_b.pos, act_b.last);
  endfunction

  function void check_byte(plane_byte_t act_b);
    plane_byte_t exp_b;
    if (pending.size() == 0) begin
      exp_b = '0;
      flag("unexpected plane byte", exp_b, act_b);
      return;
    end
    exp_b = pending.pop_front();
    if (act_b.mono !== exp_b.mono || act_b.color !== exp_b.color ||
        act_b.pos !== exp_b.pos || act_b.last !== exp_b.last)
      flag("plane byte", exp_b, act_b);
  endfunction
endclass

module bmp_row_to_epaper_bitplanes_test;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  bep_in_if  feed_if();
  bep_out_if out_if();

  plane_scoreboard board;
  bit              send_busy;
  bit              recv_busy;
  int              items_sent;

  bmp_row_to_epaper_bitplanes dut (
    .clk     (clk),
    .rst     (rst),
    .feed    (feed_if),
    .result  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  initial begin
    #4_000_000;
    $display("bmp_row_to_epaper_bitplanes: mismatch");
    $finish;
  end

  function automatic bit [7:0] pick_channel();
    case ($urandom_range(0, 3))
      0: return 8'($urandom_range(8'hEE, 8'hFF));
      1: return 8'($urandom_range(8'h7E, 8'h82));
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic feed_item_t palette_item(bit [7:0] idx, bit [7:0] r, bit [7:0] g,
                                              bit [7:0] b);
    feed_item_t it;
    it.opcode = bep_pkg::OP_PALETTE;
    it.idx    = idx;
    it.red    = r;
    it.green  = g;
    it.blue   = b;
    it.data   = 8'($urandom);
    return it;
  endfunction

  function automatic feed_item_t pixel_item(bit [7:0] d);
    feed_item_t it;
    it.opcode = bep_pkg::OP_PIXEL;
    it.idx    = 8'($urandom);
    it.red    = 8'($urandom);
    it.green  = 8'($urandom);
    it.blue   = 8'($urandom);
    it.data   = d;
    return it;
  endfunction

  task automatic send_item(feed_item_t it);
    int gap;
    gap = send_busy ? $urandom_range(0, 19) : 0;
    if (gap != 0) begin
      feed_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    feed_if.valid         <= 1'b1;
    feed_if.opcode        <= it.opcode;
    feed_if.palette_index <= it.idx;
    feed_if.red_value     <= it.red;
    feed_if.green_value   <= it.green;
    feed_if.blue_value    <= it.blue;
    feed_if.data_byte     <= it.data;
    do @(posedge clk); while (feed_if.ready !== 1'b1);
    board.note_item(it);
    items_sent++;
  endtask

  task automatic hold_for_results();
    feed_if.valid <= 1'b0;
    do @(posedge clk); while (board.pending.size() != 0);
  endtask

  task automatic apb_write(logic [1:0] reg_idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    board.write_reg(reg_idx, value);
  endtask

  // block must be quiet: palette writes and padding give no result to wait on
  task automatic set_config(bit [2:0] dep, bit m565, bit col, bit [10:0] w);
    hold_for_results();
    repeat (8) @(posedge clk);
    apb_write(bep_pkg::REG_DEPTH, 32'(dep));
    apb_write(bep_pkg::REG_RGB565, 32'(m565));
    apb_write(bep_pkg::REG_COLOR, 32'(col));
    apb_write(bep_pkg::REG_WIDTH, 32'(w));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic run_directed();
    // 1 bpp forces mono; width 0 clamps to one pixel, rest of the row is padding
    set_config(bep_pkg::DEPTH_1, 1'b0, 1'b1, 11'd0);
    send_item(palette_item(8'h00, 8'h00, 8'h00, 8'h00));
    send_item(palette_item(8'h01, 8'hFF, 8'hFF, 8'hFF));
    send_item(pixel_item(8'h80));
    send_item(pixel_item(8'h00));
    send_item(pixel_item(8'hFF));
    send_item(pixel_item(8'h7F));
    // 8 bpp palette in colour mode, classified at write time
    set_config(bep_pkg::DEPTH_8, 1'b0, 1'b1, 11'd3);
    send_item(palette_item(8'hFF, 8'hF1, 8'h00, 8'h00));
    send_item(palette_item(8'hAA, 8'h81, 8'h81, 8'h81));
    send_item(palette_item(8'h55, 8'h10, 8'hF1, 8'hF1));
    send_item(palette_item(8'h00, 8'h80, 8'h80, 8'h80));
    send_item(pixel_item(8'hFF));
    send_item(pixel_item(8'hAA));
    send_item(pixel_item(8'h55));
    send_item(pixel_item(8'h00));
    // depth code 7 acts as 32 bpp; red pixel turns black with colour off
    set_config(3'd7, 1'b1, 1'b0, 11'd1);
    send_item(pixel_item(8'h00));
    send_item(pixel_item(8'h00));
    send_item(pixel_item(8'hF1));
    send_item(pixel_item(8'hAB));
    // 565 red pixel lands on the colour plane
    set_config(bep_pkg::DEPTH_16, 1'b1, 1'b1, 11'd1);
    send_item(pixel_item(8'h00));
    send_item(pixel_item(8'hF8));
    send_item(pixel_item(8'h00));
    send_item(pixel_item(8'h00));
  endtask

  task automatic run_random();
    int       phase_no, target, pix;
    bit       pressed;
    bit [2:0] dep;
    bit [10:0] w;
    pressed = 1'b0;
    for (int i = 0; i < 256; i++)
      send_item(palette_item(8'(i), pick_channel(), pick_channel(), pick_channel()));
    phase_no = 0;
    while (items_sent < 1420) begin
      if (phase_no == 0) begin
        dep = bep_pkg::DEPTH_1;
        w   = 11'd2047;
      end else begin
        dep = 3'($urandom_range(0, 7));
        case ($urandom_range(0, 9))
          0: w = 11'd0;
          1: w = 11'd2047;
          2: w = 11'd1024;
          default: w = 11'($urandom_range(1, 40));
        endcase
      end
      set_config(dep, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), w);
      send_busy = (phase_no != 0) && ($urandom_range(0, 3) != 0);
      if (phase_no == 0) begin
        target = 140;
      end else if ($urandom_range(0, 3) != 0 && board.row_len() <= 96) begin
        // finish the current row, then whole rows
        target = (board.row_bytes < board.row_len()) ? board.row_len() - board.row_bytes : 1;
        target += board.row_len() * $urandom_range(0, 3);
      end else begin
        target = $urandom_range(20, 100);
      end
      pix = 0;
      while (pix < target) begin
        if (phase_no == 2 && !pressed && pix >= target / 2) begin
          hold_for_results();
          pressed = 1'b1;
        end
        if ($urandom_range(0, 11) == 0) begin
          send_item(palette_item(8'($urandom), pick_channel(), pick_channel(), pick_channel()));
        end else begin
          send_item(pixel_item(board.eff_depth() <= bep_pkg::DEPTH_8 ? 8'($urandom)
                                                                     : pick_channel()));
          pix++;
        end
      end
      phase_no++;
    end
  endtask

  initial begin
    plane_byte_t seen;
    int          gap;
    int          taken;
    taken        = 0;
    out_if.ready = 1'b0;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      if (taken % 50 == 0) recv_busy = ($urandom_range(0, 3) != 0);
      gap = recv_busy ? $urandom_range(0, 19) : 0;
      if (gap != 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (out_if.valid !== 1'b1);
      seen.mono  = out_if.mono_byte;
      seen.color = out_if.color_byte;
      seen.pos   = out_if.byte_position;
      seen.last  = out_if.row_last;
      board.check_byte(seen);
      taken++;
    end
  end

  initial begin
    board                 = new();
    items_sent            = 0;
    send_busy             = 1'b1;
    recv_busy             = 1'b1;
    rst                   = 1'b1;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    feed_if.valid         = 1'b0;
    feed_if.opcode        = bep_pkg::OP_PIXEL;
    feed_if.palette_index = '0;
    feed_if.red_value     = '0;
    feed_if.green_value   = '0;
    feed_if.blue_value    = '0;
    feed_if.data_byte     = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    run_random();
    hold_for_results();
    repeat (20) @(posedge clk);
    if (board.failures == 0 && board.pending.size() == 0) begin
      $display("bmp_row_to_epaper_bitplanes: match");
    end else begin
      $display("bmp_row_to_epaper_bitplanes: mismatch");
    end
    $finish;
  end
endmodule
